// ===== rtl/rrtt_pkg.sv =====
package rrtt_pkg;

  // Table size default
  localparam int SLOTS_DEFAULT = 32;

  // Field widths of the stream beats
  localparam int MODE_W   = 2;
  localparam int SLOT_W   = 5;
  localparam int STATUS_W = 2;
  localparam int CODE_W   = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [CODE_W-1:0]   code_t;

  // Slot status codes
  localparam status_t STAT_UNUSED   = 2'd0;
  localparam status_t STAT_BLOCKED  = 2'd1;
  localparam status_t STAT_RUNNABLE = 2'd2;

  // Request modes
  localparam mode_t MODE_ALLOC = 2'd0;
  localparam mode_t MODE_SET   = 2'd1;
  localparam mode_t MODE_PICK  = 2'd2;

  // Result codes
  localparam code_t RC_OK          = 2'd0;
  localparam code_t RC_NO_FREE     = 2'd1;
  localparam code_t RC_NO_RUNNABLE = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Control from the sequencer to the ring of cells
  typedef struct packed {
    logic    shift;
    status_t feed;
  } ring_ctl_t;

endpackage

// ===== rtl/round_robin_thread_table.sv =====
// Channel | Dir | Beat fields (tdata, low bit up)
// s_axis  | in  | mode[1:0], slot_id[6:2], new_status[8:7], zero pad to 16 bits
// m_axis  | out | result_slot[4:0], result_code[6:5], zero pad to 8 bits
//
// For each request the sequencer takes the beat, the status ring rotates once
// through all SLOTS cells, one cell per cycle, past the sequencer, then the
// result register is loaded.
// Reset (rst, synchronous) marks every slot unused and sets the pointer to 1.
// A new request is taken while a finished result still waits on m_axis; a
// stalled m_axis holds the next result in the sequencer until it drains.
module round_robin_thread_table
  import rrtt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // mode[1:0], slot_id[6:2], new_status[8:7]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // result_slot[4:0], result_code[6:5]
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  ring_ctl_t          ctl;
  status_t            head;
  logic [SLOT_W-1:0]  res_slot;
  code_t              res_code;

  rrtt_chain #(
    .SLOTS (SLOTS)
  ) u_chain (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .head (head)
  );

  rrtt_seq #(
    .SLOTS (SLOTS)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (s_tvalid),
    .req_ready      (s_tready),
    .req_mode       (s_tdata[1:0]),
    .req_slot_id    (s_tdata[6:2]),
    .req_new_status (s_tdata[8:7]),
    .res_valid      (m_tvalid),
    .res_ready      (m_tready),
    .res_slot       (res_slot),
    .res_code       (res_code),
    .ctl            (ctl),
    .head           (head)
  );

  // Pack the result beat
  assign m_tdata = {1'b0, res_code, res_slot};

endmodule

// ===== rtl/rrtt_cell.sv =====
module rrtt_cell
  import rrtt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    shift,
  input  status_t d,
  output status_t q
);

  // Hold one slot status; take the neighbor's value on a shift
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= STAT_UNUSED;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== rtl/rrtt_chain.sv =====
module rrtt_chain
  import rrtt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  ring_ctl_t ctl,
  output status_t   head
);

  status_t q [SLOTS];

  // Each cell takes from the next one up; the top cell takes the feed
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    status_t d;
    if (k == SLOTS - 1) begin : g_top
      assign d = ctl.feed;
    end else begin : g_mid
      assign d = q[k+1];
    end
    rrtt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ctl.shift),
      .d     (d),
      .q     (q[k])
    );
  end

  // Bottom cell shows the slot under inspection
  assign head = q[0];

endmodule

// ===== rtl/rrtt_seq.sv =====
module rrtt_seq
  import rrtt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  mode_t       req_mode,
  input  logic [SLOT_W-1:0] req_slot_id,
  input  status_t     req_new_status,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [SLOT_W-1:0] res_slot,
  output code_t       res_code,
  output ring_ctl_t   ctl,
  input  status_t     head
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

  state_t              state, state_next;
  logic [IW-1:0]       idx, idx_next;
  mode_t               mode_r, mode_r_next;
  logic [SLOT_W-1:0]   sid_r, sid_r_next;
  status_t             nst_r, nst_r_next;
  logic                hit_any, hit_any_next;
  logic                hit_after, hit_after_next;
  logic [IW-1:0]       sel_any, sel_any_next;
  logic [IW-1:0]       sel_after, sel_after_next;
  logic [PW-1:0]       rr_ptr, rr_ptr_next;
  logic                res_valid_next;
  logic [SLOT_W-1:0]   res_slot_next;
  code_t               res_code_next;
  logic [PW-1:0]       start;
  logic [IW-1:0]       pick_sel;

  assign req_ready = (state == ST_IDLE);
  assign start     = (rr_ptr == '0) ? PW'(1) : rr_ptr;
  assign pick_sel  = hit_after ? sel_after : sel_any;

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      hit_any   <= 1'b0;
      hit_after <= 1'b0;
      rr_ptr    <= PW'(1);
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      hit_any   <= hit_any_next;
      hit_after <= hit_after_next;
      rr_ptr    <= rr_ptr_next;
      res_valid <= res_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r    <= mode_r_next;
    sid_r     <= sid_r_next;
    nst_r     <= nst_r_next;
    sel_any   <= sel_any_next;
    sel_after <= sel_after_next;
    res_slot  <= res_slot_next;
    res_code  <= res_code_next;
  end

  // Next state: rotate the ring once per request, then deliver the result
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    mode_r_next    = mode_r;
    sid_r_next     = sid_r;
    nst_r_next     = nst_r;
    hit_any_next   = hit_any;
    hit_after_next = hit_after;
    sel_any_next   = sel_any;
    sel_after_next = sel_after;
    rr_ptr_next    = rr_ptr;
    res_valid_next = res_valid && !res_ready;
    res_slot_next  = res_slot;
    res_code_next  = res_code;
    ctl.shift      = 1'b0;
    ctl.feed       = head;

    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          mode_r_next    = req_mode;
          sid_r_next     = req_slot_id;
          nst_r_next     = req_new_status;
          hit_any_next   = 1'b0;
          hit_after_next = 1'b0;
          idx_next       = '0;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.shift = 1'b1;
        unique case (mode_r)
          MODE_ALLOC: begin
            // Claim the lowest unused slot above zero
            if (idx != '0 && head == STAT_UNUSED && !hit_any) begin
              ctl.feed     = STAT_BLOCKED;
              hit_any_next = 1'b1;
              sel_any_next = idx;
            end
          end
          MODE_SET: begin
            // Rewrite the named slot; drop bad codes and slots past the end
            if (32'(idx) == 32'(sid_r) && nst_r <= STAT_RUNNABLE) begin
              ctl.feed = nst_r;
            end
          end
          MODE_PICK: begin
            // Track first runnable slot above zero and first at or after the pointer
            if (idx != '0 && head == STAT_RUNNABLE) begin
              if (!hit_any) begin
                hit_any_next = 1'b1;
                sel_any_next = idx;
              end
              if (!hit_after && 32'(idx) >= 32'(start)) begin
                hit_after_next = 1'b1;
                sel_after_next = idx;
              end
            end
          end
          default: begin
          end
        endcase
        if (idx == IDX_LAST) begin
          idx_next   = '0;
          state_next = ST_DONE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_DONE: begin
        // Load the output register once it is free
        if (!res_valid || res_ready) begin
          res_valid_next = 1'b1;
          res_slot_next  = '0;
          res_code_next  = RC_OK;
          unique case (mode_r)
            MODE_ALLOC: begin
              if (hit_any) begin
                res_slot_next = SLOT_W'(sel_any);
              end else begin
                res_code_next = RC_NO_FREE;
              end
            end
            MODE_PICK: begin
              if (hit_any) begin
                res_slot_next = SLOT_W'(pick_sel);
                rr_ptr_next   = PW'(32'(pick_sel) + 32'd1);
              end else begin
                res_code_next = RC_NO_RUNNABLE;
              end
            end
            default: begin
            end
          endcase
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == ST_SCAN && idx == '0))
    else $error("accepted request did not start a scan at slot zero");

  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && idx == IDX_LAST) |=> (state == ST_DONE))
    else $error("scan did not end after a full rotation");

  a_idx_home: assert property (@(posedge clk) disable iff (rst)
    (state != ST_SCAN) |-> (idx == '0))
    else $error("ring out of alignment outside a scan");

  a_ptr_nonzero: assert property (@(posedge clk) disable iff (rst)
    rr_ptr != '0)
    else $error("round-robin pointer reached slot zero");
`endif

endmodule

// ===== tb/rrtt_result_checker.sv =====
module rrtt_result_checker
  import rrtt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  // mode[1:0], slot_id[6:2], new_status[8:7]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  // result_slot[4:0], result_code[6:5]
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  output int                     mismatch_count,
  output int                     pending
);

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    code_t             code;
  } table_result_t;

  // Shadow copy of the slot table and the round-robin pointer
  status_t       slot_table [SLOTS];
  int            rr_next;
  table_result_t expected_results [$];
  int            result_index;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("[%0t] result %0d: %s", $realtime, result_index, what);
    end
  endtask

  // Apply one request to the shadow table and return the result it produces
  function automatic table_result_t compute_table_result(input mode_t mode,
                                                         input logic [SLOT_W-1:0] id,
                                                         input status_t st);
    table_result_t res;
    int            scan_from;
    int            k;
    bit            found;
    res.slot = '0;
    res.code = RC_OK;
    found    = 1'b0;
    case (mode)
      MODE_ALLOC: begin
        // lowest unused slot, slot 0 excluded
        for (k = 1; k < SLOTS; k++) begin
          if (!found && slot_table[k] == STAT_UNUSED) begin
            slot_table[k] = STAT_BLOCKED;
            res.slot      = SLOT_W'(k);
            found         = 1'b1;
          end
        end
        if (!found) res.code = RC_NO_FREE;
      end
      MODE_SET: begin
        // drop writes of an out-of-range slot or an invalid status
        if (int'(id) < SLOTS && st <= STAT_RUNNABLE) slot_table[id] = st;
      end
      MODE_PICK: begin
        // scan from the pointer to the end, then start over at slot 1
        scan_from = (rr_next < 1) ? 1 : rr_next;
        for (k = scan_from; k < SLOTS; k++) begin
          if (!found && slot_table[k] == STAT_RUNNABLE) begin
            res.slot = SLOT_W'(k);
            found    = 1'b1;
          end
        end
        for (k = 1; k < SLOTS; k++) begin
          if (!found && slot_table[k] == STAT_RUNNABLE) begin
            res.slot = SLOT_W'(k);
            found    = 1'b1;
          end
        end
        if (found) rr_next = int'(res.slot) + 1;
        else res.code = RC_NO_RUNNABLE;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Compare result beats, then queue the prediction for each request beat
  always @(posedge clk) begin : watch
    table_result_t got;
    table_result_t want;
    if (rst) begin
      foreach (slot_table[k]) slot_table[k] = STAT_UNUSED;
      rr_next = 1;
      result_index = 0;
      expected_results.delete();
      pending <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.slot = m_tdata[SLOT_W-1:0];
        got.code = m_tdata[SLOT_W +: CODE_W];
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("beat slot %0d code %0d with no request waiting",
                                    got.slot, got.code));
        end else begin
          want = expected_results.pop_front();
          if (got.slot != want.slot)
            report_mismatch($sformatf("slot %0d, predicted %0d", got.slot, want.slot));
          if (got.code != want.code)
            report_mismatch($sformatf("code %0d, predicted %0d", got.code, want.code));
        end
        result_index++;
      end
      if (s_tvalid && s_tready) begin
        expected_results.push_back(compute_table_result(s_tdata[MODE_W-1:0],
                                                        s_tdata[MODE_W +: SLOT_W],
                                                        s_tdata[MODE_W+SLOT_W +: STATUS_W]));
      end
      pending <= expected_results.size();
    end
  end

endmodule

// ===== tb/round_robin_thread_table_tb.sv =====
module round_robin_thread_table_tb;
  import rrtt_pkg::*;

  localparam int      SLOTS        = SLOTS_DEFAULT;
  localparam int      TARGET_ITEMS = 600;
  localparam int      CYCLE_LIMIT  = 400000;
  // Codes the block must ignore
  localparam mode_t   MODE_UNUSED  = 2'd3;
  localparam status_t STAT_INVALID = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // mode[1:0], slot_id[6:2], new_status[8:7]
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // result_slot[4:0], result_code[6:5]
  logic [OUT_TDATA_W-1:0] m_tdata;

  int mismatch_count;
  int pending;
  int cycle_count = 0;
  int send_calm = 0;
  int recv_calm = 0;
  int useful_sent = 0;

  round_robin_thread_table #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  rrtt_result_checker #(
    .SLOTS(SLOTS)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .mismatch_count(mismatch_count),
    .pending       (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Draw a random idle gap per beat, with occasional stretches of back-to-back beats
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Offer one request beat and hold it until accepted
  task automatic send_request(input mode_t mode, input logic [SLOT_W-1:0] id,
                              input status_t st);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W-MODE_W-SLOT_W-STATUS_W){1'b0}}, st, id, mode};
    do @(posedge clk); while (!s_tready);
    if (!(mode == MODE_UNUSED || (mode == MODE_SET && st == STAT_INVALID))) useful_sent++;
  endtask

  // Drop the request line and hold until every predicted result has drained
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  // Result side: stall at random, then take one beat
  initial begin : result_sink
    int stall;
    @(negedge rst);
    forever begin
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : stimulus
    int          burst_kind;
    int          burst_len;
    int          roll;
    int          next_drain;
    mode_t       mode;
    logic [4:0]  id;
    status_t     st;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, wrap of the pointer, pointer past the end,
    // slot zero, invalid status, unused mode
    send_request(MODE_PICK,   5'd0,  STAT_UNUSED);
    send_request(MODE_UNUSED, 5'd21, STAT_INVALID);
    send_request(MODE_ALLOC,  5'd31, STAT_RUNNABLE);
    send_request(MODE_ALLOC,  5'd0,  STAT_UNUSED);
    send_request(MODE_SET,    5'd2,  STAT_RUNNABLE);
    send_request(MODE_PICK,   5'd0,  STAT_UNUSED);
    send_request(MODE_PICK,   5'd0,  STAT_UNUSED);
    send_request(MODE_SET,    5'd31, STAT_RUNNABLE);
    send_request(MODE_PICK,   5'd0,  STAT_UNUSED);
    send_request(MODE_PICK,   5'd31, STAT_INVALID);
    send_request(MODE_SET,    5'd0,  STAT_RUNNABLE);
    send_request(MODE_SET,    5'd2,  STAT_BLOCKED);
    send_request(MODE_SET,    5'd31, STAT_INVALID);
    send_request(MODE_PICK,   5'd0,  STAT_UNUSED);
    send_request(MODE_PICK,   5'd0,  STAT_UNUSED);
    send_request(MODE_SET,    5'd31, STAT_UNUSED);
    send_request(MODE_PICK,   5'd0,  STAT_UNUSED);
    send_request(MODE_SET,    5'd1,  STAT_UNUSED);
    send_request(MODE_ALLOC,  5'd0,  STAT_UNUSED);
    send_request(MODE_UNUSED, 5'd0,  STAT_UNUSED);
    drain_results();

    // Random: allocation bursts that fill the table, release bursts,
    // and mixed traffic of allocations, set-status, picks and the unused mode
    next_drain = 200;
    while (useful_sent < TARGET_ITEMS) begin
      burst_kind = $urandom_range(0, 9);
      burst_len  = $urandom_range(10, 30);
      if (burst_kind < 2) begin
        burst_len = $urandom_range(5, 35);
        repeat (burst_len) send_request(MODE_ALLOC, 5'($urandom), status_t'($urandom));
      end else if (burst_kind == 2) begin
        repeat (burst_len) send_request(MODE_SET, 5'($urandom_range(1, 31)), STAT_UNUSED);
      end else begin
        repeat (burst_len) begin
          roll = $urandom_range(0, 99);
          if (roll < 20)      mode = MODE_ALLOC;
          else if (roll < 55) mode = MODE_SET;
          else if (roll < 95) mode = MODE_PICK;
          else                mode = MODE_UNUSED;
          id   = ($urandom_range(0, 15) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
          roll = $urandom_range(0, 99);
          if (roll < 40)      st = STAT_RUNNABLE;
          else if (roll < 65) st = STAT_BLOCKED;
          else if (roll < 92) st = STAT_UNUSED;
          else                st = STAT_INVALID;
          send_request(mode, id, st);
        end
      end
      if (useful_sent >= next_drain) begin
        drain_results();
        next_drain += 200;
      end
    end
    s_tvalid <= 1'b0;

    // Let the last results arrive, then allow for the scan latency
    @(posedge clk);
    wait (pending == 0);
    repeat (3 * (SLOTS + 2)) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
